FILE: rtl/at_ipd_pkg.sv
// Shared types and constants for the IPD stream demultiplexer.
package at_ipd_pkg;

	// Link numbers below this value carry payload and closed notices
	localparam int unsigned LINKS       = 5;
	// Largest payload length accepted from a header
	localparam int unsigned MAX_PAYLOAD = 2048;

	localparam int unsigned LINK_W = 4;
	localparam int unsigned LEN_W  = 12;
	localparam int unsigned HIST_W = 64;

	// Register indexes on the configuration channel
	localparam logic CFG_EXPECT_PATTERN = 1'b0;
	localparam logic CFG_EXPECT_LEN     = 1'b1;

	// Request kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_ARM  = 1'b1;

	// Response event codes
	localparam logic [1:0] RESP_NONE   = 2'd0;
	localparam logic [1:0] RESP_EXPECT = 2'd1;
	localparam logic [1:0] RESP_ERROR  = 2'd2;

	// Text tags, first character in the top byte (oldest)
	localparam logic [39:0] TAG_IPD    = "+IPD,";
	localparam logic [39:0] TAG_ERROR  = "ERROR";
	localparam logic [31:0] TAG_FAIL   = "FAIL";
	localparam logic [47:0] TAG_CLOSED = "CLOSED";
	localparam logic [7:0]  CH_COMMA   = ",";
	localparam logic [7:0]  CH_COLON   = ":";
	localparam logic [7:0]  CH_ZERO    = "0";
	localparam logic [7:0]  CH_NINE    = "9";

	// Header parser modes
	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_LINK0 = 3'd1,
		MODE_LINK  = 3'd2,
		MODE_LEN0  = 3'd3,
		MODE_LEN   = 3'd4,
		MODE_DATA  = 3'd5
	} mode_t;

	// One result item
	typedef struct packed {
		logic              data_valid;
		logic [7:0]        data_byte;
		logic [LINK_W-1:0] data_link;
		logic              data_last;
		logic [1:0]        resp_event;
		logic              closed_valid;
		logic [LINK_W-1:0] closed_link;
	} result_t;

endpackage

FILE: rtl/at_ipd_stream_demux_top.sv
// Top level of the IPD stream demultiplexer: ports, parser and output buffer.
// The output buffer registers each result before it appears on the m side.
// Throughput: one request per cycle while s_tready is high; one parser pass per byte.
// A two-entry output buffer keeps s_tready high while one result waits on the m side.
// Reset (arst_n low, asynchronous): parser idle, history, arm flag and
// configuration registers cleared, output buffer empty.
module at_ipd_stream_demux_top #(
	parameter int unsigned PATTERN_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] operation
	// Result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [11:8] data_link, [15:12] closed_link
	output logic [3:0]  m_tuser,   // [0] data_valid, [2:1] resp_event, [3] closed_valid
	output logic        m_tlast,   // data_last
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	logic                push;
	logic                buf_ready;
	at_ipd_pkg::result_t result;
	at_ipd_pkg::result_t out_res;

	assign s_tready  = buf_ready;
	assign push      = s_tvalid && buf_ready;
	assign cfg_ready = 1'b1;

	at_ipd_parser #(
		.PATTERN_BYTES (PATTERN_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.operation (s_tuser),
		.rx_byte   (s_tdata),
		.result    (result)
	);

	at_ipd_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (result),
		.push_ready (buf_ready),
		.pop_valid  (m_tvalid),
		.pop_ready  (m_tready),
		.pop_data   (out_res)
	);

	// Pack result fields onto the stream
	assign m_tdata = {out_res.closed_link, out_res.data_link, out_res.data_byte};
	assign m_tuser = {out_res.closed_valid, out_res.resp_event, out_res.data_valid};
	assign m_tlast = out_res.data_last;

endmodule

FILE: rtl/at_ipd_parser.sv
// Header parser, payload counter, reply matcher and configuration registers.
module at_ipd_parser #(
	parameter int unsigned PATTERN_BYTES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [63:0]           cfg_data,
	input  logic                  push,
	input  logic                  operation,
	input  logic [7:0]            rx_byte,
	output at_ipd_pkg::result_t   result
);

	localparam int unsigned PAT_W = 8 * PATTERN_BYTES;

	// Configuration
	logic [PAT_W-1:0] expect_pattern_q;
	logic [3:0]       expect_len_q;

	// Parser state
	at_ipd_pkg::mode_t                  mode_q, mode_n;
	logic [at_ipd_pkg::LINK_W-1:0]      link_q, link_n;
	logic [at_ipd_pkg::LEN_W-1:0]       len_q, len_n;
	logic [at_ipd_pkg::LEN_W-1:0]       left_q, left_n;
	logic [at_ipd_pkg::HIST_W-1:0]      hist_q, hist_n;
	logic                               armed_q, armed_n;

	logic                               in_payload;
	logic                               digit;
	logic [3:0]                         dval;
	logic [7:0]                         link_mul;
	logic [15:0]                        len_mul;
	logic [at_ipd_pkg::HIST_W-1:0]      hist_sh;
	logic [3:0]                         n_eff;
	logic                               pat_match;
	logic [7:0]                         close_ch;

	assign in_payload = (mode_q == at_ipd_pkg::MODE_DATA) && (left_q != '0);
	assign hist_sh    = {hist_q[at_ipd_pkg::HIST_W-9:0], rx_byte};
	assign digit      = (rx_byte >= at_ipd_pkg::CH_ZERO) && (rx_byte <= at_ipd_pkg::CH_NINE);
	assign dval       = digit ? 4'(rx_byte - at_ipd_pkg::CH_ZERO) : 4'd0;
	// times ten plus digit
	assign link_mul   = ({4'd0, link_q} << 3) + ({4'd0, link_q} << 1) + {4'd0, dval};
	assign len_mul    = ({4'd0, len_q} << 3) + ({4'd0, len_q} << 1) + {12'd0, dval};
	assign close_ch   = hist_sh[63:56];

	// Clamp the pattern length
	assign n_eff = (expect_len_q > 4'(PATTERN_BYTES)) ? 4'(PATTERN_BYTES) : expect_len_q;

	// Per-byte compare of the newest bytes against the expected reply
	always_comb begin
		pat_match = 1'b1;
		for (int i = 0; i < PATTERN_BYTES; i++) begin
			if ((4'(i) < n_eff) && (hist_sh[8*i +: 8] != expect_pattern_q[8*i +: 8]))
				pat_match = 1'b0;
		end
	end

	// Next state of the header parser
	always_comb begin
		mode_n = mode_q;
		link_n = link_q;
		len_n  = len_q;
		left_n = left_q;
		if (operation == at_ipd_pkg::OP_ARM) begin
			mode_n = mode_q;
		end else if (in_payload) begin
			left_n = left_q - 1'b1;
			if (left_n == '0)
				mode_n = at_ipd_pkg::MODE_IDLE;
		end else begin
			unique case (mode_q)
				at_ipd_pkg::MODE_LINK0: begin
					if (digit) begin
						link_n = dval;
						mode_n = at_ipd_pkg::MODE_LINK;
					end else
						mode_n = at_ipd_pkg::MODE_IDLE;
				end
				at_ipd_pkg::MODE_LINK: begin
					if (digit)
						link_n = (link_mul > 8'd15) ? 4'd15 : link_mul[3:0];
					else if (rx_byte == at_ipd_pkg::CH_COMMA) begin
						len_n  = '0;
						mode_n = at_ipd_pkg::MODE_LEN0;
					end else
						mode_n = at_ipd_pkg::MODE_IDLE;
				end
				at_ipd_pkg::MODE_LEN0: begin
					if (digit) begin
						len_n  = 12'(dval);
						mode_n = at_ipd_pkg::MODE_LEN;
					end else
						mode_n = at_ipd_pkg::MODE_IDLE;
				end
				at_ipd_pkg::MODE_LEN: begin
					if (digit)
						len_n = (len_mul > 16'd4095) ? 12'd4095 : len_mul[11:0];
					else if (rx_byte == at_ipd_pkg::CH_COLON && len_q != '0 &&
					         len_q <= 12'(at_ipd_pkg::MAX_PAYLOAD)) begin
						left_n = len_q;
						mode_n = at_ipd_pkg::MODE_DATA;
					end else
						mode_n = at_ipd_pkg::MODE_IDLE;
				end
				default: mode_n = at_ipd_pkg::MODE_IDLE;
			endcase
			// A fresh header tag starts a new header
			if (mode_n == at_ipd_pkg::MODE_IDLE && hist_sh[39:0] == at_ipd_pkg::TAG_IPD) begin
				link_n = '0;
				len_n  = '0;
				mode_n = at_ipd_pkg::MODE_LINK0;
			end
		end
	end

	// Result, history and arm flag
	always_comb begin
		result  = '0;
		hist_n  = hist_q;
		armed_n = armed_q;
		if (operation == at_ipd_pkg::OP_ARM) begin
			armed_n = 1'b1;
		end else if (in_payload) begin
			if (link_q < 4'(at_ipd_pkg::LINKS)) begin
				result.data_valid = 1'b1;
				result.data_byte  = rx_byte;
				result.data_link  = link_q;
				result.data_last  = (left_q == 12'd1);
			end
		end else begin
			hist_n = hist_sh;
			priority if (armed_q && n_eff != 4'd0 && pat_match) begin
				result.resp_event = at_ipd_pkg::RESP_EXPECT;
				armed_n = 1'b0;
				hist_n  = '0;
			end else if (hist_sh[39:0] == at_ipd_pkg::TAG_ERROR ||
			             hist_sh[31:0] == at_ipd_pkg::TAG_FAIL) begin
				result.resp_event = at_ipd_pkg::RESP_ERROR;
				armed_n = 1'b0;
				hist_n  = '0;
			end else if (hist_sh[47:0] == at_ipd_pkg::TAG_CLOSED &&
			             hist_sh[55:48] == at_ipd_pkg::CH_COMMA) begin
				if (close_ch >= at_ipd_pkg::CH_ZERO && close_ch <= at_ipd_pkg::CH_NINE &&
				    8'(close_ch - at_ipd_pkg::CH_ZERO) < 8'(at_ipd_pkg::LINKS)) begin
					result.closed_valid = 1'b1;
					result.closed_link  = 4'(close_ch - at_ipd_pkg::CH_ZERO);
				end
			end else begin
				result.resp_event = at_ipd_pkg::RESP_NONE;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_pattern_q <= '0;
			expect_len_q     <= '0;
		end else if (cfg_we) begin
			if (cfg_index == at_ipd_pkg::CFG_EXPECT_PATTERN)
				expect_pattern_q <= cfg_data[PAT_W-1:0];
			else
				expect_len_q <= cfg_data[3:0];
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= at_ipd_pkg::MODE_IDLE;
			link_q  <= '0;
			len_q   <= '0;
			left_q  <= '0;
			hist_q  <= '0;
			armed_q <= 1'b0;
		end else if (push) begin
			mode_q  <= mode_n;
			link_q  <= link_n;
			len_q   <= len_n;
			left_q  <= left_n;
			hist_q  <= hist_n;
			armed_q <= armed_n;
		end
	end

`ifndef NO_ASSERTIONS
	// Payload mode always has bytes still to come
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == at_ipd_pkg::MODE_DATA |-> left_q != '0)
		else $error("payload mode with zero bytes left");

	// A payload byte never carries a text event
	a_payload_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result.data_valid |-> (!result.closed_valid && result.resp_event == at_ipd_pkg::RESP_NONE))
		else $error("payload byte with text event");

	// Arming request sets the arm flag
	a_arm: assert property (@(posedge clk) disable iff (!arst_n)
		push && operation == at_ipd_pkg::OP_ARM |=> armed_q)
		else $error("arm request lost");

	// A reply event clears the history
	a_hist_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push && result.resp_event != at_ipd_pkg::RESP_NONE |=> hist_q == '0)
		else $error("history not cleared after reply event");
`endif

endmodule

FILE: rtl/at_ipd_out_buf.sv
// Two-entry output buffer decoupling result delivery from request intake.
module at_ipd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  at_ipd_pkg::result_t push_data,
	output logic                push_ready,
	output logic                pop_valid,
	input  logic                pop_ready,
	output at_ipd_pkg::result_t pop_data
);

	logic                main_valid_q, skid_valid_q;
	at_ipd_pkg::result_t main_q, skid_q;
	logic                pop;

	assign push_ready = !skid_valid_q;
	assign pop_valid  = main_valid_q;
	assign pop_data   = main_q;
	assign pop        = main_valid_q && pop_ready;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				main_valid_q <= push;
		end else if (push) begin
			if (!main_valid_q)
				main_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q)
				main_q <= skid_q;
			else if (push)
				main_q <= push_data;
		end else if (push) begin
			if (!main_valid_q)
				main_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	// Skid entry only holds data behind a full main entry
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry without main entry");

	// No request taken while both entries are full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("push into full buffer");

	// A held result with no pop stays in the main entry
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		main_valid_q && !pop_ready |=> main_valid_q)
		else $error("result lost while stalled");
`endif

endmodule

FILE: bench/at_ipd_stream_demux_checker.sv
// Checker for the IPD stream demultiplexer: predicts each result and compares it.
`timescale 1ns / 1ps

module at_ipd_stream_demux_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic [3:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	output int          pending,
	output int          fail_count
);

	localparam int unsigned REPLY_BYTES = 8;

	// Shadow of the parser state and configuration
	at_ipd_pkg::mode_t                 mode;
	logic [at_ipd_pkg::LINK_W-1:0]     hdr_link;
	logic [at_ipd_pkg::LEN_W-1:0]      hdr_len;
	logic [at_ipd_pkg::LEN_W-1:0]      left;
	logic [at_ipd_pkg::HIST_W-1:0]     hist;
	logic                              armed;
	logic [63:0]                       reply_pat;
	logic [3:0]                        reply_len;

	at_ipd_pkg::result_t results_q[$];
	at_ipd_pkg::result_t want_r;
	at_ipd_pkg::result_t got_r;
	int      res_no = 0;
	int      errors = 0;

	task automatic report_mismatch(string what, int got, int want);
		$display("checker: result %0d: %s is %0d, expected %0d", res_no, what, got, want);
		errors++;
	endtask

	task automatic check_field(string what, int got, int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	// Advance the shadow parser by one request and return the result it causes
	function automatic at_ipd_pkg::result_t demux_step(logic op, logic [7:0] rx);
		at_ipd_pkg::result_t r;
		logic        digit;
		int          dval;
		int          acc;
		int          n;
		logic [63:0] mask;
		logic [7:0]  c;
		r = '0;
		if (op == at_ipd_pkg::OP_ARM) begin
			armed = 1'b1;
			return r;
		end

		// payload bytes bypass the history
		if (mode == at_ipd_pkg::MODE_DATA && left != 0) begin
			left = left - 1'b1;
			if (hdr_link < at_ipd_pkg::LINKS) begin
				r.data_valid = 1'b1;
				r.data_byte  = rx;
				r.data_link  = hdr_link;
				r.data_last  = (left == 0);
			end
			if (left == 0)
				mode = at_ipd_pkg::MODE_IDLE;
			return r;
		end

		hist  = {hist[at_ipd_pkg::HIST_W-9:0], rx};
		digit = (rx >= at_ipd_pkg::CH_ZERO) && (rx <= at_ipd_pkg::CH_NINE);
		dval  = digit ? int'(rx - at_ipd_pkg::CH_ZERO) : 0;

		// header fields
		case (mode)
			at_ipd_pkg::MODE_LINK0: begin
				if (digit) begin
					hdr_link = 4'(dval);
					mode     = at_ipd_pkg::MODE_LINK;
				end else
					mode = at_ipd_pkg::MODE_IDLE;
			end
			at_ipd_pkg::MODE_LINK: begin
				if (digit) begin
					acc      = int'(hdr_link) * 10 + dval;
					hdr_link = (acc > 15) ? 4'd15 : 4'(acc);
				end else if (rx == at_ipd_pkg::CH_COMMA) begin
					hdr_len = '0;
					mode    = at_ipd_pkg::MODE_LEN0;
				end else
					mode = at_ipd_pkg::MODE_IDLE;
			end
			at_ipd_pkg::MODE_LEN0: begin
				if (digit) begin
					hdr_len = 12'(dval);
					mode    = at_ipd_pkg::MODE_LEN;
				end else
					mode = at_ipd_pkg::MODE_IDLE;
			end
			at_ipd_pkg::MODE_LEN: begin
				if (digit) begin
					acc     = int'(hdr_len) * 10 + dval;
					hdr_len = (acc > 4095) ? 12'd4095 : 12'(acc);
				end else if (rx == at_ipd_pkg::CH_COLON && hdr_len != 0 &&
				             hdr_len <= at_ipd_pkg::MAX_PAYLOAD) begin
					left = hdr_len;
					mode = at_ipd_pkg::MODE_DATA;
				end else
					mode = at_ipd_pkg::MODE_IDLE;
			end
			default: mode = at_ipd_pkg::MODE_IDLE;
		endcase

		if (mode == at_ipd_pkg::MODE_IDLE && hist[39:0] == at_ipd_pkg::TAG_IPD) begin
			hdr_link = '0;
			hdr_len  = '0;
			mode     = at_ipd_pkg::MODE_LINK0;
		end

		// text matches, armed reply first
		n    = (reply_len > REPLY_BYTES) ? REPLY_BYTES : int'(reply_len);
		mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
		if (armed && n > 0 && ((hist ^ reply_pat) & mask) == '0) begin
			r.resp_event = at_ipd_pkg::RESP_EXPECT;
			armed        = 1'b0;
			hist         = '0;
		end else if (hist[39:0] == at_ipd_pkg::TAG_ERROR ||
		             hist[31:0] == at_ipd_pkg::TAG_FAIL) begin
			r.resp_event = at_ipd_pkg::RESP_ERROR;
			armed        = 1'b0;
			hist         = '0;
		end else if (hist[47:0] == at_ipd_pkg::TAG_CLOSED &&
		             hist[55:48] == at_ipd_pkg::CH_COMMA) begin
			c = hist[63:56];
			if (c >= at_ipd_pkg::CH_ZERO && c <= at_ipd_pkg::CH_NINE &&
			    (c - at_ipd_pkg::CH_ZERO) < at_ipd_pkg::LINKS) begin
				r.closed_valid = 1'b1;
				r.closed_link  = 4'(c - at_ipd_pkg::CH_ZERO);
			end
		end
		return r;
	endfunction

	// Watch all three channels; results are checked before new requests are predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode       = at_ipd_pkg::MODE_IDLE;
			hdr_link   = '0;
			hdr_len    = '0;
			left       = '0;
			hist       = '0;
			armed      = 1'b0;
			reply_pat  = '0;
			reply_len  = '0;
			results_q.delete();
			pending    <= 0;
			fail_count <= errors;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r.data_valid   = m_tuser[0];
				got_r.data_byte    = m_tdata[7:0];
				got_r.data_link    = m_tdata[11:8];
				got_r.data_last    = m_tlast;
				got_r.resp_event   = m_tuser[2:1];
				got_r.closed_valid = m_tuser[3];
				got_r.closed_link  = m_tdata[15:12];
				if (results_q.size() == 0)
					report_mismatch("result with no request pending", 1, 0);
				else begin
					want_r = results_q.pop_front();
					check_field("data_valid", got_r.data_valid, want_r.data_valid);
					check_field("data_byte", got_r.data_byte, want_r.data_byte);
					check_field("data_link", got_r.data_link, want_r.data_link);
					check_field("data_last", got_r.data_last, want_r.data_last);
					check_field("resp_event", got_r.resp_event, want_r.resp_event);
					check_field("closed_valid", got_r.closed_valid, want_r.closed_valid);
					check_field("closed_link", got_r.closed_link, want_r.closed_link);
				end
				res_no++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == at_ipd_pkg::CFG_EXPECT_PATTERN)
					reply_pat = cfg_data;
				else
					reply_len = cfg_data[3:0];
			end
			if (s_tvalid && s_tready)
				results_q.push_back(demux_step(s_tuser, s_tdata));
			pending    <= results_q.size();
			fail_count <= errors;
		end
	end

endmodule

FILE: bench/at_ipd_stream_demux_top_tb.sv
// Testbench top for the IPD stream demultiplexer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module at_ipd_stream_demux_top_tb;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       op;
		logic [7:0] rx;
	} req_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = at_ipd_pkg::OP_BYTE;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = at_ipd_pkg::CFG_EXPECT_PATTERN;
	logic [63:0] cfg_data  = '0;

	int          pending;
	int          fail_count;
	int          cycles    = 0;
	logic [9:0]  sink_tick = '0;

	req_t        tx_q[$];
	logic [63:0] cur_pat;
	logic [3:0]  cur_len;

	at_ipd_stream_demux_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	at_ipd_stream_demux_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver: four stall patterns in turn, chosen by the top bits of sink_tick
	always @(posedge clk) begin
		sink_tick <= sink_tick + 1'b1;
		case (sink_tick[9:8])
			2'd0:    m_tready <= 1'b1;
			2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
			2'd2:    m_tready <= (sink_tick[2:0] == 3'd7);
			default: m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("at_ipd_stream_demux_top_tb: errors");
			$finish;
		end
	end

	task automatic push_byte(logic [7:0] v);
		tx_q.push_back({at_ipd_pkg::OP_BYTE, v});
	endtask

	task automatic push_arm();
		tx_q.push_back({at_ipd_pkg::OP_ARM, 8'($urandom_range(0, 255))});
	endtask

	task automatic push_text(string s);
		int i;
		for (i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Header followed by count payload bytes, with the odd arm request mixed in
	task automatic push_ipd(string link_txt, string len_txt, int count);
		int i;
		push_text({"+IPD,", link_txt, ",", len_txt, ":"});
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 15) == 0)
				push_arm();
			push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// The valid tail of the current expected reply, oldest byte first
	task automatic push_reply();
		int n;
		int i;
		n = (cur_len > 8) ? 8 : int'(cur_len);
		for (i = n - 1; i >= 0; i--)
			push_byte(cur_pat[8*i +: 8]);
	endtask

	task automatic gen_random(int budget);
		int    base;
		int    k;
		int    d;
		int    n;
		int    i;
		string noise_chars;
		noise_chars = "+IPD,:0123456789EROKFAILCS\r\n";
		base = tx_q.size();
		while (tx_q.size() - base < budget) begin
			k = $urandom_range(0, 99);
			d = $urandom_range(0, 9);
			n = $urandom_range(1, 12);
			if (k < 30)
				// well-formed header; links from LINKS up are dropped
				push_ipd($sformatf("%0d", $urandom_range(0, 6)), $sformatf("%0d", n), n);
			else if (k < 36) begin
				// leading zeros, saturating numbers, rejected lengths
				case ($urandom_range(0, 2))
					0: push_ipd($sformatf("0%0d", d), $sformatf("00%0d", n), n);
					1: push_ipd("123", "3", 3);
					default: begin
						case ($urandom_range(0, 2))
							0:       push_text($sformatf("+IPD,%0d,0:", d));
							1:       push_text($sformatf("+IPD,%0d,2049:", d));
							default: push_text($sformatf("+IPD,%0d,99999:", d));
						endcase
					end
				endcase
			end else if (k < 42) begin
				// broken headers
				case ($urandom_range(0, 4))
					0:       push_text("+IPD,:");
					1:       push_text("+IPD,1x");
					2:       push_text("+IPD,2,:");
					3:       push_text("+IPD,1,5;");
					default: push_text("+IPD,+IPD,0,1:Z");
				endcase
			end else if (k < 54) begin
				push_arm();
				for (i = $urandom_range(0, 3); i > 0; i--)
					push_byte(8'($urandom_range(0, 255)));
				push_reply();
			end else if (k < 62) begin
				case ($urandom_range(0, 2))
					0:       push_text("\r\nERROR\r\n");
					1:       push_text("\r\nFAIL\r\n");
					default: push_text("ERRO+FAI");
				endcase
			end else if (k < 72) begin
				case ($urandom_range(0, 3))
					0:       push_text($sformatf("x%0d;CLOSED\r\n", d));
					1:       push_text("A,CLOSED\r\n");
					default: push_text($sformatf("%0d,CLOSED\r\n", d));
				endcase
			end else if (k < 76)
				push_arm();
			else begin
				for (i = $urandom_range(1, 6); i > 0; i--) begin
					if ($urandom_range(0, 1) == 0)
						push_byte(8'($urandom_range(0, 255)));
					else
						push_byte(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
				end
			end
		end
	endtask

	// Sender: bursts of requests with random gaps
	task automatic send_requests();
		int burst;
		int gap;
		while (tx_q.size() != 0) begin
			burst = $urandom_range(1, 40);
			while (burst != 0 && tx_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tuser  <= tx_q[0].op;
				s_tdata  <= tx_q[0].rx;
				do @(posedge clk); while (!s_tready);
				void'(tx_q.pop_front());
				burst--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom_range(0, 255));
				s_tuser  <= 1'($urandom_range(0, 1));
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(logic idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(logic [63:0] pat, logic [3:0] len);
		cur_pat = pat;
		cur_len = len;
		write_reg(at_ipd_pkg::CFG_EXPECT_PATTERN, pat);
		write_reg(at_ipd_pkg::CFG_EXPECT_LEN, {60'd0, len});
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int budget);
		gen_random(budget);
		send_requests();
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: replies, errors, closed notices, payload edges
		set_config("OK\r\n", 4'd4);
		push_arm();
		push_text("OK\r\n");
		push_text("ERROR");
		push_text("FAIL");
		push_arm();
		push_text("4,CLOSED");
		push_text("5,CLOSED");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_ipd("0", "1", 1);
		push_ipd("4", "2", 2);
		push_ipd("5", "1", 1);
		run_phase(90);

		set_config("SEND OK\n", 4'd8);
		run_phase(90);

		// length above the pattern width counts as full width
		set_config({$urandom, $urandom}, 4'd15);
		run_phase(80);

		set_config('1, 4'd1);
		run_phase(80);

		// matching off; one longer payload
		set_config('0, 4'd0);
		push_ipd("1", "40", 40);
		run_phase(70);

		set_config("ready", 4'd3);
		run_phase(100);

		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("at_ipd_stream_demux_top_tb: clean");
		else
			$display("at_ipd_stream_demux_top_tb: errors");
		$finish;
	end

endmodule
